### sv/asc_pkg.sv
// Shared types and constants for the Ascon-128a encryption core.
// Holds the request/response item structs, the sponge state type and algorithm constants.
// No dependencies.
package asc_pkg;

   localparam int INIT_ROUNDS  = 12;
   localparam int BLOCK_ROUNDS = 8;
   localparam int RATE_BYTES   = 128 / 8;
   localparam int ADDR_W       = 4;

   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [3:0]  ROUND_LAST  = 4'd11;
   localparam logic [3:0]  INIT_START  = 4'(12 - INIT_ROUNDS);
   localparam logic [3:0]  BLOCK_START = 4'(12 - BLOCK_ROUNDS);
   localparam logic [4:0]  FULL_BYTES  = 5'(RATE_BYTES);
   localparam logic [63:0] ASCON_IV    = {8'h80, 8'(8 * RATE_BYTES), 8'(INIT_ROUNDS),
                                          8'(BLOCK_ROUNDS), 32'h0};

   // Register select is paddr bit 3 (byte address 0 or 8)
   localparam logic KEY_HIGH_SEL = 1'b0;
   localparam logic KEY_LOW_SEL  = 1'b1;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_AD    = 2'd1;
   localparam logic [1:0] REQ_PT    = 2'd2;

   typedef logic [4:0][63:0] asc_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  valid_bytes;
      logic        phase_last;
   } asc_req_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic [4:0]  out_bytes;
      logic        is_tag;
      logic        last_out;
   } asc_rsp_type;

endpackage

### sv/ascon128a_aead_encrypt_core.sv
// Ascon-128a AEAD encryption core: sequencer, sponge state, key registers, output register.
// Depends on asc_pkg and asc_round (one shared permutation round, used once per cycle).
// Ciphertext is taken from the sponge and registered for output after its item is taken; the tag
// is registered after the finalisation permutation. A new item is taken only in idle, once the
// permutation of the last one is through; rsp_stall holding a result delays this further.
// Reset (synchronous): idle, no message open, key zero.
module ascon128a_aead_encrypt_core (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  asc_pkg::asc_req_type        req_data,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output asc_pkg::asc_rsp_type        rsp_data,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [asc_pkg::ADDR_W-1:0]  paddr,
   input  logic [63:0]                 pwdata,
   output logic [63:0]                 prdata,
   output logic                        pready
);
   import asc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_EMIT_CT, ST_EMIT_TAG} st_type;

   // What to do once the current permutation finishes
   typedef enum logic [2:0] {
      POST_INIT, POST_AD, POST_AD_FULL, POST_ADLAST, POST_PT, POST_PT_FULL, POST_FIN
   } post_type;

   // Message phase: awaiting start, initialised without AD, inside AD, plaintext
   typedef enum logic [1:0] {PH_IDLE, PH_INIT, PH_AD, PH_PT} phase_type;

   // Leading-byte mask of a 128-bit big-endian block
   function automatic logic [127:0] lead_mask(input logic [4:0] n);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < n) m[127 - 8*i -: 8] = 8'hff;
      end
      return m;
   endfunction

   // Padding byte at byte position n (n below 16)
   function automatic logic [127:0] pad_word(input logic [4:0] n);
      logic [127:0] p;
      p = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) == n) p[127 - 8*i -: 8] = PAD_BYTE;
      end
      return p;
   endfunction

   st_type        state_ff, state_in;
   post_type      post_ff, post_in;
   phase_type     phase_ff, phase_in;
   logic [3:0]    round_ff, round_in;
   asc_state_type x_ff, x_in;
   logic [4:0]    ctn_ff, ctn_in;
   asc_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   key_high_ff, key_high_in;
   logic [63:0]   key_low_ff, key_low_in;

   asc_state_type x_rnd;
   logic          req_acc;
   logic          rsp_free;
   logic          rsp_load;
   logic          tag_load;
   logic          cfg_wr;
   logic [4:0]    n_clamp;
   logic [127:0]  blk;
   logic [127:0]  blk_pad;
   logic [127:0]  ct_word;

   asc_round u_round (
      .x_i     (x_ff),
      .round_i (round_ff),
      .x_o     (x_rnd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Final blocks longer than the rate count as full
   assign n_clamp = (req_data.valid_bytes > FULL_BYTES) ? FULL_BYTES : req_data.valid_bytes;
   assign blk     = {req_data.data_high, req_data.data_low};
   assign blk_pad = (blk & lead_mask(n_clamp)) ^ pad_word(n_clamp);
   assign ct_word = {x_ff[0], x_ff[1]} & lead_mask(ctn_ff);

   // Configuration port: always ready, decode on address bit 3
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[3] == KEY_LOW_SEL) ? key_low_ff : key_high_ff;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (cfg_wr) begin
         if (paddr[3] == KEY_LOW_SEL) key_low_in = pwdata;
         else if (paddr[3] == KEY_HIGH_SEL) key_high_in = pwdata;
      end
   end

   always_comb begin
      state_in  = state_ff;
      post_in   = post_ff;
      phase_in  = phase_ff;
      round_in  = round_ff;
      x_in      = x_ff;
      ctn_in    = ctn_ff;
      rsp_in    = rsp_ff;
      rsp_load  = 1'b0;
      tag_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.req_type)
                  REQ_START: begin
                     // Load IV, key and nonce; a start always opens a fresh message
                     x_in     = {req_data.data_low, req_data.data_high, key_low_ff,
                                 key_high_ff, ASCON_IV};
                     round_in = INIT_START;
                     post_in  = POST_INIT;
                     phase_in = PH_INIT;
                     state_in = ST_ROUND;
                  end
                  REQ_AD: begin
                     if (phase_ff == PH_INIT || phase_ff == PH_AD) begin
                        round_in = BLOCK_START;
                        state_in = ST_ROUND;
                        if (!req_data.phase_last) begin
                           x_in[0]  = x_ff[0] ^ req_data.data_high;
                           x_in[1]  = x_ff[1] ^ req_data.data_low;
                           post_in  = POST_AD;
                           phase_in = PH_AD;
                        end else if (n_clamp == FULL_BYTES) begin
                           // Full final block, then an empty padded one
                           x_in[0]  = x_ff[0] ^ req_data.data_high;
                           x_in[1]  = x_ff[1] ^ req_data.data_low;
                           post_in  = POST_AD_FULL;
                           phase_in = PH_PT;
                        end else begin
                           x_in[0]  = x_ff[0] ^ blk_pad[127:64];
                           x_in[1]  = x_ff[1] ^ blk_pad[63:0];
                           post_in  = POST_ADLAST;
                           phase_in = PH_PT;
                        end
                     end
                  end
                  REQ_PT: begin
                     if (phase_ff == PH_INIT || phase_ff == PH_PT) begin
                        // Domain separation when no AD was sent
                        if (phase_ff == PH_INIT) x_in[4] = x_ff[4] ^ 64'd1;
                        state_in = ST_EMIT_CT;
                        phase_in = PH_PT;
                        if (!req_data.phase_last || n_clamp == FULL_BYTES) begin
                           x_in[0] = x_ff[0] ^ req_data.data_high;
                           x_in[1] = x_ff[1] ^ req_data.data_low;
                           ctn_in  = FULL_BYTES;
                           post_in = req_data.phase_last ? POST_PT_FULL : POST_PT;
                        end else begin
                           x_in[0] = x_ff[0] ^ blk_pad[127:64];
                           x_in[1] = x_ff[1] ^ blk_pad[63:0];
                           ctn_in  = n_clamp;
                           post_in = POST_FIN;
                        end
                        if (req_data.phase_last) phase_in = PH_IDLE;
                     end
                  end
                  default: ;  // unused request code: drop the item
               endcase
            end
         end

         ST_EMIT_CT: begin
            // Hold until the output register is free, then present the ciphertext
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{out_high: ct_word[127:64], out_low: ct_word[63:0],
                            out_bytes: ctn_ff, is_tag: 1'b0, last_out: 1'b0};
               state_in = ST_ROUND;
               if (post_ff == POST_FIN) begin
                  x_in[2]  = x_ff[2] ^ key_high_ff;
                  x_in[3]  = x_ff[3] ^ key_low_ff;
                  round_in = INIT_START;
               end else begin
                  round_in = BLOCK_START;
               end
            end
         end

         ST_ROUND: begin
            x_in = x_rnd;
            if (round_ff != ROUND_LAST) begin
               round_in = round_ff + 4'd1;
            end else begin
               unique case (post_ff)
                  POST_INIT: begin
                     x_in[3]  = x_rnd[3] ^ key_high_ff;
                     x_in[4]  = x_rnd[4] ^ key_low_ff;
                     state_in = ST_IDLE;
                  end
                  POST_AD, POST_PT: state_in = ST_IDLE;
                  POST_AD_FULL: begin
                     x_in[0]  = x_rnd[0] ^ {PAD_BYTE, 56'h0};
                     round_in = BLOCK_START;
                     post_in  = POST_ADLAST;
                  end
                  POST_ADLAST: begin
                     x_in[4]  = x_rnd[4] ^ 64'd1;
                     state_in = ST_IDLE;
                  end
                  POST_PT_FULL: begin
                     // Empty padded block, then key into the capacity for finalisation
                     x_in[0]  = x_rnd[0] ^ {PAD_BYTE, 56'h0};
                     x_in[2]  = x_rnd[2] ^ key_high_ff;
                     x_in[3]  = x_rnd[3] ^ key_low_ff;
                     round_in = INIT_START;
                     post_in  = POST_FIN;
                  end
                  POST_FIN: begin
                     x_in[3]  = x_rnd[3] ^ key_high_ff;
                     x_in[4]  = x_rnd[4] ^ key_low_ff;
                     state_in = ST_EMIT_TAG;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_EMIT_TAG: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               tag_load = 1'b1;
               rsp_in   = '{out_high: x_ff[3], out_low: x_ff[4],
                            out_bytes: FULL_BYTES, is_tag: 1'b1, last_out: 1'b1};
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         post_ff      <= POST_INIT;
         phase_ff     <= PH_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         post_ff      <= post_in;
         phase_ff     <= phase_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
      end
      x_ff   <= x_in;
      ctn_ff <= ctn_in;
      rsp_ff <= rsp_in;
   end

   // Round counter never runs past the last round
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff <= ROUND_LAST)
      else $error("round counter out of range");

   // Rounds advance by one each cycle until the last
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && round_ff != ROUND_LAST
      |=> state_ff == ST_ROUND && round_ff == $past(round_ff) + 4'd1)
      else $error("round counter skipped");

   // A tag closes the message
   a_tag_closes: assert property (@(posedge clock) disable iff (reset)
      tag_load |-> phase_ff == PH_IDLE)
      else $error("tag issued with message still open");

   // Output register is only loaded when free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("pending response overwritten");

endmodule

### sv/asc_round.sv
// One Ascon permutation round: constant addition, S-box layer, linear diffusion.
// Depends on asc_pkg for the state type.
module asc_round (
   input  asc_pkg::asc_state_type x_i,
   input  logic [3:0]             round_i,
   output asc_pkg::asc_state_type x_o
);
   import asc_pkg::*;

   function automatic logic [63:0] rotr(input logic [63:0] v, input int s);
      rotr = (v >> s) | (v << (64 - s));
   endfunction

   logic [7:0]  rc;
   logic [63:0] a0, a1, a2, a3, a4;
   logic [63:0] t0, t1, t2, t3, t4;
   logic [63:0] b0, b1, b2, b3, b4;
   logic [63:0] c0, c1, c2, c3, c4;

   assign rc = {4'hf - round_i, round_i};

   // Constant addition and S-box input mixing
   assign a0 = x_i[0] ^ x_i[4];
   assign a4 = x_i[4] ^ x_i[3];
   assign a2 = x_i[2] ^ {56'h0, rc} ^ x_i[1];
   assign a1 = x_i[1];
   assign a3 = x_i[3];

   // Chi-like nonlinear layer
   assign t0 = ~a0 & a1;
   assign t1 = ~a1 & a2;
   assign t2 = ~a2 & a3;
   assign t3 = ~a3 & a4;
   assign t4 = ~a4 & a0;

   assign b0 = a0 ^ t1;
   assign b1 = a1 ^ t2;
   assign b2 = a2 ^ t3;
   assign b3 = a3 ^ t4;
   assign b4 = a4 ^ t0;

   assign c1 = b1 ^ b0;
   assign c0 = b0 ^ b4;
   assign c3 = b3 ^ b2;
   assign c2 = ~b2;
   assign c4 = b4;

   // Linear diffusion per word
   assign x_o[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
   assign x_o[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
   assign x_o[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
   assign x_o[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
   assign x_o[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);

endmodule

### sim/tb.sv
// Self-checking testbench for the Ascon-128a encryption core.
// Drives start, associated-data and plaintext items, predicts ciphertext and tag
// results with its own sponge model, and depends on asc_pkg and the core only.
module tb;
   import asc_pkg::*;

   localparam logic [1:0]  REQ_UNUSED  = 2'd3;               // type code the core must ignore
   localparam logic [63:0] IV_WORD     = 64'h8080_0c08_0000_0000;
   localparam logic [63:0] PAD_WORD    = 64'h80;
   localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
   localparam int          SETTLE_CYC  = 40;                 // margin over trailing rounds
   localparam int          RSP_HOLD    = 300;                // long receiver hold-off
   localparam int          WD_LIMIT    = 3000;               // cycles with no handshake at all
   localparam int          PHASE_ITEMS = 100;

   typedef enum logic [1:0] {PH_IDLE, PH_NO_AD, PH_AD, PH_TEXT} msg_phase_type;

   // One row of the directed table. Rows marked dropped are out of order or of the unused
   // type: the expectation is typed in as no result and no change of the sponge.
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] dh;
      logic [63:0] dl;
      logic [4:0]  nb;
      logic        last;
      logic        dropped;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   asc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   asc_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   // Predicted core state
   logic [63:0]   sponge_prd [0:4];
   msg_phase_type msg_phase_prd;
   logic [63:0]   key_hi_prd;
   logic [63:0]   key_lo_prd;
   asc_rsp_type   ct_tag_q [$];     // ciphertext blocks and tags still to come

   int unsigned err_cnt;
   int unsigned applied_cnt;        // items that took effect in the predictor
   int unsigned idle_cnt;
   bit          calm;               // no idling on either side while set
   logic        hold_rsp;

   stim_row_type dir_tab [0:25] = '{
      // plaintext, AD and the unused type before any start: all dropped
      '{REQ_PT,     64'h0,                   64'h0,                   5'd16, 1'b1, 1'b1},
      '{REQ_AD,     ALL_ONES,                ALL_ONES,                5'd16, 1'b0, 1'b1},
      '{REQ_UNUSED, ALL_ONES,                ALL_ONES,                5'd31, 1'b1, 1'b1},
      // zero nonce with zero key, then an empty message with no AD
      '{REQ_START,  64'h0,                   64'h0,                   5'd0,  1'b0, 1'b0},
      '{REQ_PT,     64'h0,                   64'h0,                   5'd0,  1'b1, 1'b0},
      // all-ones nonce, full AD blocks, AD after close, full final plaintext
      '{REQ_START,  ALL_ONES,                ALL_ONES,                5'd31, 1'b1, 1'b0},
      '{REQ_AD,     ALL_ONES,                ALL_ONES,                5'd0,  1'b0, 1'b0},
      '{REQ_AD,     ALL_ONES,                ALL_ONES,                5'd16, 1'b1, 1'b0},
      '{REQ_AD,     64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd5,  1'b1, 1'b1},
      '{REQ_PT,     ALL_ONES,                ALL_ONES,                5'd0,  1'b0, 1'b0},
      '{REQ_PT,     ALL_ONES,                ALL_ONES,                5'd16, 1'b1, 1'b0},
      // empty final AD, plaintext one byte short of a block
      '{REQ_START,  64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd0,  1'b0, 1'b0},
      '{REQ_AD,     64'ha5a5_5a5a_c3c3_3c3c, 64'h9696_6969_0f0f_f0f0, 5'd0,  1'b1, 1'b0},
      '{REQ_PT,     64'h1122_3344_5566_7788, 64'h99aa_bbcc_ddee_ff00, 5'd15, 1'b1, 1'b0},
      // short final AD, zero block, plaintext of exactly one word
      '{REQ_START,  64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 5'd0,  1'b0, 1'b0},
      '{REQ_AD,     64'hdead_beef_cafe_f00d, 64'h0bad_c0de_1234_5678, 5'd7,  1'b1, 1'b0},
      '{REQ_PT,     64'h0,                   64'h0,                   5'd16, 1'b0, 1'b0},
      '{REQ_PT,     64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988, 5'd8,  1'b1, 1'b0},
      // plaintext inside open AD is dropped; over-long counts act as 16
      '{REQ_START,  64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555, 5'd0,  1'b0, 1'b0},
      '{REQ_AD,     64'h0f1e_2d3c_4b5a_6978, 64'h8796_a5b4_c3d2_e1f0, 5'd16, 1'b0, 1'b0},
      '{REQ_PT,     64'h0f1e_2d3c_4b5a_6978, 64'h8796_a5b4_c3d2_e1f0, 5'd16, 1'b1, 1'b1},
      '{REQ_AD,     64'h1357_9bdf_0246_8ace, 64'hfdb9_7531_eca8_6420, 5'd31, 1'b1, 1'b0},
      '{REQ_PT,     64'h2468_ace0_1357_9bdf, 64'h0246_8ace_1357_9bdf, 5'd17, 1'b1, 1'b0},
      // a start while a message is open restarts it
      '{REQ_START,  64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 5'd0,  1'b0, 1'b0},
      '{REQ_START,  64'hffee_ddcc_bbaa_9988, 64'h7766_5544_3322_1100, 5'd0,  1'b0, 1'b0},
      '{REQ_PT,     64'hc001_d00d_face_b00c, 64'h1234_5678_9abc_def0, 5'd1,  1'b1, 1'b0}
   };

   ascon128a_aead_encrypt_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] ror64(logic [63:0] v, int s);
      return (v >> s) | (v << (64 - s));
   endfunction

   // Run the last nr rounds of the twelve-round schedule on the predicted sponge.
   function automatic void sponge_rounds(int nr);
      logic [63:0] t0, t1, t2, t3, t4;
      for (int r = 12 - nr; r < 12; r++) begin
         sponge_prd[2] ^= {56'd0, 4'(15 - r), 4'(r)};
         sponge_prd[0] ^= sponge_prd[4];
         sponge_prd[4] ^= sponge_prd[3];
         sponge_prd[2] ^= sponge_prd[1];
         t0 = ~sponge_prd[0] & sponge_prd[1];
         t1 = ~sponge_prd[1] & sponge_prd[2];
         t2 = ~sponge_prd[2] & sponge_prd[3];
         t3 = ~sponge_prd[3] & sponge_prd[4];
         t4 = ~sponge_prd[4] & sponge_prd[0];
         sponge_prd[0] ^= t1;
         sponge_prd[1] ^= t2;
         sponge_prd[2] ^= t3;
         sponge_prd[3] ^= t4;
         sponge_prd[4] ^= t0;
         sponge_prd[1] ^= sponge_prd[0];
         sponge_prd[0] ^= sponge_prd[4];
         sponge_prd[3] ^= sponge_prd[2];
         sponge_prd[2] = ~sponge_prd[2];
         sponge_prd[0] ^= ror64(sponge_prd[0], 19) ^ ror64(sponge_prd[0], 28);
         sponge_prd[1] ^= ror64(sponge_prd[1], 61) ^ ror64(sponge_prd[1], 39);
         sponge_prd[2] ^= ror64(sponge_prd[2], 1) ^ ror64(sponge_prd[2], 6);
         sponge_prd[3] ^= ror64(sponge_prd[3], 10) ^ ror64(sponge_prd[3], 17);
         sponge_prd[4] ^= ror64(sponge_prd[4], 7) ^ ror64(sponge_prd[4], 41);
      end
   endfunction

   // Mask of the leading n bytes of a big-endian word
   function automatic logic [63:0] lead_mask(int n);
      if (n <= 0) return 64'd0;
      if (n >= 8) return ALL_ONES;
      return ALL_ONES << (64 - 8 * n);
   endfunction

   // XOR n (0..15) bytes plus the padding byte into the rate
   function automatic void absorb_padded(logic [63:0] dh, logic [63:0] dl, int n);
      sponge_prd[0] ^= dh & lead_mask(n);
      sponge_prd[1] ^= dl & lead_mask(n - 8);
      if (n < 8) sponge_prd[0] ^= PAD_WORD << (56 - 8 * n);
      else sponge_prd[1] ^= PAD_WORD << (56 - 8 * (n - 8));
   endfunction

   function automatic void push_result(logic [63:0] h, logic [63:0] l, int n, logic tag);
      asc_rsp_type r;
      r.out_high  = h;
      r.out_low   = l;
      r.out_bytes = 5'(n);
      r.is_tag    = tag;
      r.last_out  = tag;
      ct_tag_q.push_back(r);
   endfunction

   function automatic void load_tag();
      sponge_prd[2] ^= key_hi_prd;
      sponge_prd[3] ^= key_lo_prd;
      sponge_rounds(INIT_ROUNDS);
      sponge_prd[3] ^= key_hi_prd;
      sponge_prd[4] ^= key_lo_prd;
      push_result(sponge_prd[3], sponge_prd[4], 16, 1'b1);
   endfunction

   // Advance the predicted core by one accepted item; return 1 if it took effect.
   function automatic bit ascon_encrypt_step(asc_req_type it);
      int n;
      n = (it.valid_bytes > 5'd16) ? 16 : int'(it.valid_bytes);
      case (it.req_type)
         REQ_START: begin
            sponge_prd[0] = IV_WORD;
            sponge_prd[1] = key_hi_prd;
            sponge_prd[2] = key_lo_prd;
            sponge_prd[3] = it.data_high;
            sponge_prd[4] = it.data_low;
            sponge_rounds(INIT_ROUNDS);
            sponge_prd[3] ^= key_hi_prd;
            sponge_prd[4] ^= key_lo_prd;
            msg_phase_prd = PH_NO_AD;
            return 1'b1;
         end
         REQ_AD: begin
            if (msg_phase_prd != PH_NO_AD && msg_phase_prd != PH_AD) return 1'b0;
            if (!it.phase_last) begin
               sponge_prd[0] ^= it.data_high;
               sponge_prd[1] ^= it.data_low;
               sponge_rounds(BLOCK_ROUNDS);
               msg_phase_prd = PH_AD;
               return 1'b1;
            end
            if (n == 16) begin
               sponge_prd[0] ^= it.data_high;
               sponge_prd[1] ^= it.data_low;
               sponge_rounds(BLOCK_ROUNDS);
               n = 0;
            end
            absorb_padded(it.data_high, it.data_low, n);
            sponge_rounds(BLOCK_ROUNDS);
            sponge_prd[4] ^= 64'd1;
            msg_phase_prd = PH_TEXT;
            return 1'b1;
         end
         REQ_PT: begin
            if (msg_phase_prd == PH_NO_AD) begin
               sponge_prd[4] ^= 64'd1;
               msg_phase_prd = PH_TEXT;
            end else if (msg_phase_prd != PH_TEXT) begin
               return 1'b0;
            end
            if (!it.phase_last || n == 16) begin
               sponge_prd[0] ^= it.data_high;
               sponge_prd[1] ^= it.data_low;
               push_result(sponge_prd[0], sponge_prd[1], 16, 1'b0);
               sponge_rounds(BLOCK_ROUNDS);
               if (!it.phase_last) return 1'b1;
               absorb_padded(64'd0, 64'd0, 0);
            end else begin
               absorb_padded(it.data_high, it.data_low, n);
               push_result(sponge_prd[0] & lead_mask(n), sponge_prd[1] & lead_mask(n - 8),
                           n, 1'b0);
            end
            load_tag();
            msg_phase_prd = PH_IDLE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- result side

   task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         err_cnt++;
      end
   endtask

   // Compare every accepted result with the oldest expectation, field by field.
   always @(posedge clock) begin : rsp_check
      asc_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (ct_tag_q.size() == 0) begin
            $display("%0t: result with none pending, expected nothing, got %h",
                     $time, rsp_data);
            err_cnt++;
         end else begin
            want = ct_tag_q.pop_front();
            report_field("out_high", want.out_high, rsp_data.out_high);
            report_field("out_low", want.out_low, rsp_data.out_low);
            report_field("out_bytes", 64'(want.out_bytes), 64'(rsp_data.out_bytes));
            report_field("is_tag", 64'(want.is_tag), 64'(rsp_data.is_tag));
            report_field("last_out", 64'(want.last_out), 64'(rsp_data.last_out));
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver stall: random runs, or one long hold-off counted here on request.
   initial begin : rsp_side
      int unsigned run;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp === 1'b1) begin
            hold_rsp  <= 1'b0;
            rsp_stall <= 1'b1;
            for (run = 0; run < RSP_HOLD; run++) @(posedge clock);
         end else if (!calm) begin
            run = pick_gap();
            if (run > 0) begin
               rsp_stall <= 1'b1;
               repeat (run) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run if no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (psel === 1'b1 && penable === 1'b1)) begin
         idle_cnt <= 0;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
      if (idle_cnt >= WD_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results pending",
                  $time, idle_cnt, ct_tag_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- request side

   function automatic asc_req_type mk_item(logic [1:0] kind, logic [63:0] dh, logic [63:0] dl,
                                           logic [4:0] nb, logic last);
      asc_req_type it;
      it.req_type    = kind;
      it.data_high   = dh;
      it.data_low    = dl;
      it.valid_bytes = nb;
      it.phase_last  = last;
      return it;
   endfunction

   function automatic logic [63:0] rnd64();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return 64'd0;
      if (k == 1) return ALL_ONES;
      return {$urandom, $urandom};
   endfunction

   // Byte count of a closing block: mostly 0..16, sometimes beyond 16.
   function automatic logic [4:0] tail_count();
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(0, 16));
   endfunction

   // Offer one item, hold it until taken, then predict and idle for a while.
   task automatic send_item(asc_req_type it, bit predict);
      int unsigned gap;
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict && ascon_encrypt_step(it)) applied_cnt++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every expected result, then let trailing rounds finish.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (ct_tag_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Write a key word (setup then access), then read it back.
   task automatic key_write(logic sel, logic [63:0] val);
      logic [63:0] rd;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 3'b000};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (sel == KEY_HIGH_SEL) key_hi_prd = val;
      else key_lo_prd = val;
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      report_field("key readback", val, rd);
   endtask

   // Start plus zero to three AD blocks, the last one padded.
   task automatic send_head();
      int unsigned n_ad;
      send_item(mk_item(REQ_START, rnd64(), rnd64(), 5'($urandom), 1'($urandom)), 1'b1);
      n_ad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
      for (int i = 1; i < n_ad; i++)
         send_item(mk_item(REQ_AD, rnd64(), rnd64(), 5'($urandom), 1'b0), 1'b1);
      if (n_ad > 0)
         send_item(mk_item(REQ_AD, rnd64(), rnd64(), tail_count(), 1'b1), 1'b1);
   endtask

   // One to four plaintext blocks, the last one closing the message.
   task automatic send_text();
      int unsigned n_pt;
      n_pt = $urandom_range(1, 4);
      for (int i = 1; i < n_pt; i++)
         send_item(mk_item(REQ_PT, rnd64(), rnd64(), 5'($urandom), 1'b0), 1'b1);
      send_item(mk_item(REQ_PT, rnd64(), rnd64(), tail_count(), 1'b1), 1'b1);
   endtask

   // Mostly whole messages; some lone random items and abandoned messages.
   task automatic send_message();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 12) begin
         send_item(mk_item(2'($urandom), rnd64(), rnd64(), 5'($urandom), 1'($urandom)),
                   1'b1);
      end else if (k < 17) begin
         send_head();
      end else begin
         send_head();
         send_text();
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      stim_row_type row;
      int unsigned  goal;
      err_cnt       = 0;
      applied_cnt   = 0;
      idle_cnt      = 0;
      calm          = 1'b0;
      key_hi_prd    = 64'd0;
      key_lo_prd    = 64'd0;
      msg_phase_prd = PH_IDLE;
      for (int i = 0; i < 5; i++) sponge_prd[i] = 64'd0;
      hold_rsp  <= 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed pass with an all-zero key
      key_write(KEY_HIGH_SEL, 64'd0);
      key_write(KEY_LOW_SEL, 64'd0);
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         send_item(mk_item(row.kind, row.dh, row.dl, row.nb, row.last), !row.dropped);
      end

      // Random phases, each under a fresh key. Phase 1 runs without idling,
      // phase 2 holds the receiver off for a long stretch and leaves its last
      // message open, so that phase 3 finishes it under a changed key.
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               key_write(KEY_HIGH_SEL, ALL_ONES);
               key_write(KEY_LOW_SEL, ALL_ONES);
            end
            2: begin
               key_write(KEY_HIGH_SEL, 64'h8000_0000_0000_0000);
               key_write(KEY_LOW_SEL, 64'h0000_0000_0000_0001);
            end
            4: begin
               key_write(KEY_HIGH_SEL, 64'd0);
               key_write(KEY_LOW_SEL, ALL_ONES);
            end
            default: begin
               key_write(KEY_HIGH_SEL, {$urandom, $urandom});
               key_write(KEY_LOW_SEL, {$urandom, $urandom});
            end
         endcase
         calm = (ph == 1);
         if (ph == 2) hold_rsp <= 1'b1;
         if (ph == 3) send_text();
         goal = applied_cnt + PHASE_ITEMS;
         while (applied_cnt < goal) send_message();
         if (ph == 2) send_head();
      end

      // Drain, let the core settle, then give the verdict
      wait_drained();
      if (err_cnt == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
